### hdl/assert_macros.svh
// assertion helpers shared by the datapath modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

### hdl/ptsd_pkg.sv
package ptsd_pkg;

  // operand slice for the partial-product multipliers
  localparam int MUL_CHUNK = 32;

  // width of the distance field on the output word
  localparam int DIST_W = 33;

  // which part of the segment the distance refers to
  localparam logic [1:0] CASE_TX     = 2'd0;
  localparam logic [1:0] CASE_OBS    = 2'd1;
  localparam logic [1:0] CASE_IMPACT = 2'd2;

  typedef struct packed {
    logic [1:0] near;
    logic       degen;
  } ptsd_tag_t;

endpackage

### hdl/ptsd_mul.sv
module ptsd_mul
  import ptsd_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH = MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int PW = AW + BW;

  logic [AW-1:0]    ma;
  logic [BW-1:0]    mb;
  logic             neg1;
  logic             neg2;
  logic [NA*CH-1:0] pa;
  logic [NB*CH-1:0] pb;
  logic [2*CH-1:0]  pp [NA][NB];
  logic [PW-1:0]    acc;

  assign pa = (NA*CH)'(ma);
  assign pb = (NB*CH)'(mb);

  // stage 1: magnitudes and product sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[AW-1] ^ b[BW-1];
      ma   <= a[AW-1] ? (~a + AW'(1)) : a;
      mb   <= b[BW-1] ? (~b + BW'(1)) : b;
    end
  end

  // stage 2: slice products
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= {{CH{1'b0}}, pa[i*CH +: CH]} * {{CH{1'b0}}, pb[j*CH +: CH]};
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i][j]) << (CH*(i+j)));
      end
    end
  end

  // stage 3: recombine and restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg2 ? $signed(~acc + PW'(1)) : $signed(acc);
    end
  end

endmodule

### hdl/ptsd_div.sv
`include "assert_macros.svh"

module ptsd_div
  import ptsd_pkg::*;
#(
  parameter int NW = 132,
  parameter int LW = 66,
  parameter int SW = 69
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NW-1:0]    num,
  input  logic [LW-1:0]    den,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [NW-LW-1:0] quo,
  output logic [SW-1:0]    out_side
);

  // quotient is known to fit below 2^QW, so the top part of num starts as remainder
  localparam int QW = NW - LW;

  logic [LW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [LW-1:0] dv   [QW+1];
  logic [SW-1:0] sd   [QW+1];
  logic          vld  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[NW-1:QW];
      low[0] <= num[QW-1:0];
      q[0]   <= '0;
      dv[0]  <= den;
      sd[0]  <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [LW:0] trial;
    logic        ge;

    assign trial = {rem[k], low[k][QW-1]};
    assign ge    = trial >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? LW'(trial - {1'b0, dv[k]}) : trial[LW-1:0];
        low[k+1] <= low[k] << 1;
        q[k+1]   <= {q[k][QW-2:0], ge};
        dv[k+1]  <= dv[k];
        sd[k+1]  <= sd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign out_side  = sd[QW];

  `ASSERT_IMPLY(a_div_rem_below_den, clk, rst, vld[QW] && dv[QW] != '0, rem[QW] < dv[QW], "divider remainder not below divisor")

endmodule

### hdl/ptsd_sqrt.sv
`include "assert_macros.svh"

module ptsd_sqrt
  import ptsd_pkg::*;
#(
  parameter int RW = 66
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RW-1:0]     rad_in,
  input  ptsd_tag_t         in_tag,
  output logic              out_valid,
  output logic [RW/2-1:0]   root_out,
  output ptsd_tag_t         out_tag
);

  localparam int RTW  = RW / 2;
  localparam int REMW = RTW + 3;

  logic [REMW-1:0] rem  [RTW+1];
  logic [RW-1:0]   rad  [RTW+1];
  logic [RTW-1:0]  root [RTW+1];
  ptsd_tag_t       tg   [RTW+1];
  logic            vld  [RTW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      rad[0]  <= rad_in;
      root[0] <= '0;
      tg[0]   <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // digit-by-digit root, two radicand bits per stage
  for (genvar k = 0; k < RTW; k++) begin : g_step
    logic [REMW-1:0] t;
    logic [REMW-1:0] trial;
    logic            ge;

    assign t     = {rem[k][REMW-3:0], rad[k][RW-1:RW-2]};
    assign trial = {1'b0, root[k], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? (t - trial) : t;
        rad[k+1]  <= rad[k] << 2;
        root[k+1] <= {root[k][RTW-2:0], ge};
        tg[k+1]   <= tg[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid = vld[RTW];
  assign root_out  = root[RTW];
  assign out_tag   = tg[RTW];

  `ASSERT_IMPLY(a_sqrt_rem_bound, clk, rst, vld[RTW], rem[RTW] <= (REMW'(root[RTW]) << 1), "root remainder above twice the root")

endmodule

### hdl/point_to_segment_distance_unit.sv
// point to segment distance unit
//
// input stream: one word per query, nine signed coordinates (observer,
// transmitter, test point). output stream: one word per query with the
// truncated distance from the point to the observer-transmitter segment,
// which end or the interior it refers to, and a degenerate-link flag
// (observer equal to transmitter: distance zero, end code transmitter).
//
// throughput: one word per cycle while s_tready is high, fully pipelined.
// the restoring divider (2*COORD_WIDTH + 3 stages: an input register, then
// one quotient bit per stage) and the square root (COORD_WIDTH + 2 stages:
// an input register, then one root bit per stage) sit behind nine front-end
// stages of differences, split multipliers and sums.
//
// reset clears every valid bit; no clearing pass, ready right after reset.
// a stalled receiver: the output register holds, one more word lands in the
// skid register, then s_tready drops and the whole pipeline freezes in
// place, so nothing is lost or repeated.
`include "assert_macros.svh"

module point_to_segment_distance_unit
  import ptsd_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // observer_x, observer_y, observer_z, transmitter_x, transmitter_y,
  // transmitter_z, point_x, point_y, point_z, then zero fill
  input  logic [(9*COORD_WIDTH+7)/8*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // min_distance, then zero fill
  output logic [39:0] m_tdata,
  // nearest_case, degenerate
  output logic [2:0]  m_tuser
);

  localparam int W   = COORD_WIDTH;
  localparam int VW  = W + 1;       // coordinate differences
  localparam int PW  = 2 * VW;      // first-level products
  localparam int DW  = 2 * W + 4;   // dot products
  localparam int RW  = 2 * W + 2;   // squared norms, quotient, radicand
  localparam int CW  = 2 * W + 3;   // cross-product components
  localparam int SQW = 2 * CW;      // squared cross components
  localparam int NW  = 4 * W + 4;   // squared cross norm
  localparam int RTW = RW / 2;      // root
  localparam int TW  = $bits(ptsd_tag_t);
  localparam int SW  = RW + TW;
  localparam int OW  = 40;

  // global advance: the pipeline moves whenever the skid slot is free
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // stage 1: differences
  logic signed [VW-1:0] ox [3];
  logic signed [VW-1:0] tx [3];
  logic signed [VW-1:0] px [3];
  logic signed [VW-1:0] d1  [3];
  logic signed [VW-1:0] vt1 [3];
  logic signed [VW-1:0] vo1 [3];
  logic                 deg_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ox[i] = {s_tdata[i*W+W-1], s_tdata[i*W +: W]};
      tx[i] = {s_tdata[(3+i)*W+W-1], s_tdata[(3+i)*W +: W]};
      px[i] = {s_tdata[(6+i)*W+W-1], s_tdata[(6+i)*W +: W]};
    end
    deg_in = (ox[0] == tx[0]) && (ox[1] == tx[1]) && (ox[2] == tx[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i]  <= ox[i] - tx[i];
        vt1[i] <= px[i] - tx[i];
        vo1[i] <= px[i] - ox[i];
      end
    end
  end

  // valid and degenerate flag through the front end (stages 1 to 9)
  logic vld [1:9];
  logic deg [1:9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 9; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= 9; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg[1] <= deg_in;
      for (int k = 2; k <= 9; k++) begin
        deg[k] <= deg[k-1];
      end
    end
  end

  // stages 2-4: products
  // 0-2 dot(d,vt), 3-5 dot(d,vo), 6-8 |vt|^2, 9-11 |vo|^2, 12-14 |d|^2,
  // 15-20 the two halves of each cross component
  logic signed [PW-1:0] pr [21];

  for (genvar i = 0; i < 3; i++) begin : g_mul
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    ptsd_mul #(.AW(VW), .BW(VW)) u_ta (
      .clk(clk), .en(en), .a(d1[i]), .b(vt1[i]), .p(pr[i]));
    ptsd_mul #(.AW(VW), .BW(VW)) u_oa (
      .clk(clk), .en(en), .a(d1[i]), .b(vo1[i]), .p(pr[3+i]));
    ptsd_mul #(.AW(VW), .BW(VW)) u_vt (
      .clk(clk), .en(en), .a(vt1[i]), .b(vt1[i]), .p(pr[6+i]));
    ptsd_mul #(.AW(VW), .BW(VW)) u_vo (
      .clk(clk), .en(en), .a(vo1[i]), .b(vo1[i]), .p(pr[9+i]));
    ptsd_mul #(.AW(VW), .BW(VW)) u_dd (
      .clk(clk), .en(en), .a(d1[i]), .b(d1[i]), .p(pr[12+i]));
    ptsd_mul #(.AW(VW), .BW(VW)) u_cxa (
      .clk(clk), .en(en), .a(d1[J]), .b(vt1[K]), .p(pr[15+i]));
    ptsd_mul #(.AW(VW), .BW(VW)) u_cxb (
      .clk(clk), .en(en), .a(d1[K]), .b(vt1[J]), .p(pr[18+i]));
  end

  // stage 5: sums
  logic signed [DW-1:0] prx [21];
  logic signed [DW-1:0] ta5;
  logic signed [DW-1:0] oa5;
  logic [RW-1:0]        vt2_5;
  logic [RW-1:0]        vo2_5;
  logic [RW-1:0]        len5;
  logic signed [CW-1:0] cx5 [3];

  always_comb begin
    for (int n = 0; n < 21; n++) begin
      prx[n] = {{(DW-PW){pr[n][PW-1]}}, pr[n]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta5   <= prx[0] + prx[1] + prx[2];
      oa5   <= prx[3] + prx[4] + prx[5];
      vt2_5 <= RW'(prx[6] + prx[7] + prx[8]);
      vo2_5 <= RW'(prx[9] + prx[10] + prx[11]);
      len5  <= RW'(prx[12] + prx[13] + prx[14]);
      for (int i = 0; i < 3; i++) begin
        cx5[i] <= CW'(prx[15+i] - prx[18+i]);
      end
    end
  end

  // stages 6-8: squared cross components
  logic signed [SQW-1:0] sq [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ptsd_mul #(.AW(CW), .BW(CW)) u_sq (
      .clk(clk), .en(en), .a(cx5[i]), .b(cx5[i]), .p(sq[i]));
  end

  // stage 6: beyond-an-end decision, then delayed to line up with the squares
  logic          beyond;
  logic          lt;
  logic [DW-1:0] ata;
  logic [DW-1:0] aoa;
  logic [1:0]    near [6:8];
  logic [RW-1:0] endrad [6:8];
  logic [RW-1:0] len [6:8];

  always_comb begin
    ata    = ta5[DW-1] ? (~ta5 + DW'(1)) : ta5;
    aoa    = oa5[DW-1] ? (~oa5 + DW'(1)) : oa5;
    beyond = (ta5 != '0) && (oa5 != '0) && (ta5[DW-1] == oa5[DW-1]);
    // ties go to the observer end
    lt     = ata < aoa;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near[6]   <= beyond ? (lt ? CASE_TX : CASE_OBS) : CASE_IMPACT;
      endrad[6] <= lt ? vt2_5 : vo2_5;
      len[6]    <= len5;
      for (int k = 7; k <= 8; k++) begin
        near[k]   <= near[k-1];
        endrad[k] <= endrad[k-1];
        len[k]    <= len[k-1];
      end
    end
  end

  // stage 9: squared cross norm, tag
  logic [NW-1:0] csum9;
  logic [RW-1:0] len9;
  logic [RW-1:0] endrad9;
  ptsd_tag_t     tag9;

  always_ff @(posedge clk) begin
    if (en) begin
      csum9      <= NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2]);
      len9       <= len[8];
      endrad9    <= endrad[8];
      tag9.near  <= deg[8] ? CASE_TX : near[8];
      tag9.degen <= deg[8];
    end
  end

  // divider: floor(cross norm squared / link length squared)
  logic          div_valid;
  logic [RW-1:0] quo;
  logic [SW-1:0] div_side;
  logic [RW-1:0] div_endrad;
  ptsd_tag_t     div_tag;

  ptsd_div #(.NW(NW), .LW(RW), .SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld[9]),
    .num      (csum9),
    .den      (len9),
    .in_side  ({endrad9, tag9}),
    .out_valid(div_valid),
    .quo      (quo),
    .out_side (div_side)
  );

  assign div_endrad = div_side[SW-1:TW];
  assign div_tag    = div_side[TW-1:0];

  // square root of either the end distance squared or the quotient
  logic           sq_valid;
  logic [RTW-1:0] root;
  ptsd_tag_t      sq_tag;
  logic [RW-1:0]  rad;

  assign rad = (div_tag.near == CASE_IMPACT) ? quo : div_endrad;

  ptsd_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (div_valid),
    .rad_in   (rad),
    .in_tag   (div_tag),
    .out_valid(sq_valid),
    .root_out (root),
    .out_tag  (sq_tag)
  );

  // saturate to the output field
  logic [DIST_W-1:0] dist_sat;
  logic [DIST_W-1:0] dist_val;

  if (RTW > DIST_W) begin : g_sat
    assign dist_sat = (|root[RTW-1:DIST_W]) ? {DIST_W{1'b1}} : root[DIST_W-1:0];
  end else begin : g_nosat
    assign dist_sat = DIST_W'(root);
  end

  assign dist_val = sq_tag.degen ? '0 : dist_sat;

  // output register and skid slot
  logic [DIST_W-1:0] out_dist;
  ptsd_tag_t         out_tag;
  logic [DIST_W-1:0] skid_dist;
  ptsd_tag_t         skid_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= sq_valid;
        end
      end else if (sq_valid && en) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_dist <= skid_dist;
        out_tag  <= skid_tag;
      end else if (sq_valid) begin
        out_dist <= dist_val;
        out_tag  <= sq_tag;
      end
    end else if (sq_valid && en) begin
      skid_dist <= dist_val;
      skid_tag  <= sq_tag;
    end
  end

  assign m_tdata = OW'(out_dist);
  assign m_tuser = {out_tag.degen, out_tag.near};

  `ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, m_tvalid, "skid slot filled while output empty")
  `ASSERT_IMPLY(a_degen_zero, clk, rst, m_tvalid && out_tag.degen, out_dist == '0 && out_tag.near == CASE_TX, "degenerate link with nonzero result")

endmodule
